[src/nearest_lower_symbol_search_macros.svh]
`ifndef NEAREST_LOWER_SYMBOL_SEARCH_MACROS_SVH
`define NEAREST_LOWER_SYMBOL_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NLSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NLSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/nlss_pkg.sv]
package nlss_pkg;

  // Default sizing of the symbol tables.
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  // Register reset values.
  localparam logic [31:0] MAX_OFFSET_RESET = 32'd4096;

  // Item command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Table select codes.
  localparam logic TBL_USER     = 1'b0;
  localparam logic TBL_INTERNAL = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_USER_COUNT     = 2'd0;
  localparam logic [1:0] CFG_INTERNAL_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_OFFSET     = 2'd2;

  // One input item.
  typedef struct packed {
    logic        cmd;
    logic        table_sel;
    logic [7:0]  entry_index;
    logic [31:0] entry_value;
    logic [31:0] address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        found;
    logic [7:0]  symbol_index;
    logic [31:0] offset;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[src/nearest_lower_symbol_search.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  nlss_pkg::in_item_t
// out_      output     out_valid/ out_stall nlss_pkg::out_item_t
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// A write item is stored when it is taken and returns no result.
// A query stalls the input until its answer is registered, with one compare per
// table entry read from the registered memory port; count is capped at TABLE_DEPTH.
// Reset is synchronous and active low; the table contents are not cleared.
// The result register holds a finished answer while out_stall is high; a query
// waits in its final state until that register is free.
module nearest_lower_symbol_search #(
  parameter int TABLE_DEPTH = nlss_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = nlss_pkg::DEF_VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nlss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nlss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import nlss_pkg::*;

  // Memory address, scan counter and datapath widths.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  // Symbol tables.
  logic [VALUE_WIDTH-1:0] user_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] internal_mem [TABLE_DEPTH];

  // Configuration registers.
  logic [8:0]  user_count_r;
  logic [8:0]  internal_count_r;
  logic [31:0] max_offset_r;

  // Sequencer and scan state.
  state_t         state_r, state_nxt;
  logic [CW-1:0]  scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           sel_r, sel_nxt;
  logic [DW-1:0]  addr_r, addr_nxt;
  logic [DW-1:0]  best_r, best_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  logic           hit_r, hit_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pend_idx_r, pend_idx_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Memory ports.
  logic [VALUE_WIDTH-1:0] rd_user_r, rd_internal_r;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   wr_en;

  // Helpers.
  logic           in_xfer;
  logic           out_free;
  logic [8:0]     sel_count;
  logic [DW-1:0]  cand_val;
  logic [DW-1:0]  cand_dist;
  logic           cand_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Table writes: only indexes inside the table are stored.
  assign wr_addr = AW'(in_data.entry_index);
  assign wr_data = VALUE_WIDTH'(in_data.entry_value);
  assign wr_en   = in_xfer && (in_data.cmd == CMD_WRITE) &&
                   (32'(in_data.entry_index) < DEPTH32);
  assign rd_addr = scan_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en && (in_data.table_sel == TBL_USER)) begin
      user_mem[wr_addr] <= wr_data;
    end
    rd_user_r <= user_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && (in_data.table_sel == TBL_INTERNAL)) begin
      internal_mem[wr_addr] <= wr_data;
    end
    rd_internal_r <= internal_mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r     <= '0;
      internal_count_r <= '0;
      max_offset_r     <= MAX_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USER_COUNT:     user_count_r     <= cfg_wdata[8:0];
        CFG_INTERNAL_COUNT: internal_count_r <= cfg_wdata[8:0];
        CFG_MAX_OFFSET:     max_offset_r     <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // Shared compare unit: candidate must sit at or below the address and beat
  // the best distance so far; a tie keeps the earlier entry.
  assign cand_val  = DW'((sel_r == TBL_INTERNAL) ? rd_internal_r : rd_user_r);
  assign cand_dist = addr_r - cand_val;
  assign cand_take = pend_r && (cand_val <= addr_r) && (cand_dist < best_r);

  assign sel_count = (in_data.table_sel == TBL_INTERNAL) ? internal_count_r : user_count_r;

  // Sequencer next state and datapath.
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    count_nxt     = count_r;
    sel_nxt       = sel_r;
    addr_nxt      = addr_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    hit_nxt       = hit_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cand_take) begin
      best_nxt     = cand_dist;
      best_idx_nxt = pend_idx_r;
      hit_nxt      = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.cmd == CMD_QUERY)) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          sel_nxt      = in_data.table_sel;
          addr_nxt     = DW'(VALUE_WIDTH'(in_data.address));
          best_nxt     = DW'(max_offset_r);
          best_idx_nxt = '0;
          hit_nxt      = 1'b0;
          if (32'(sel_count) > DEPTH32) begin
            count_nxt = CW'(TABLE_DEPTH);
          end else begin
            count_nxt = CW'(sel_count);
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle, then drain the last compare.
        if (scan_idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hit_r) begin
            out_data_nxt.found        = 1'b1;
            out_data_nxt.symbol_index = 8'(best_idx_r);
            out_data_nxt.offset       = best_r[31:0];
          end else begin
            out_data_nxt.found        = 1'b0;
            out_data_nxt.symbol_index = '0;
            out_data_nxt.offset       = addr_r[31:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    count_r    <= count_nxt;
    sel_r      <= sel_nxt;
    addr_r     <= addr_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

`include "nearest_lower_symbol_search_macros.svh"

  `NLSS_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, scan_idx_r <= count_r, "scan index passed the entry count")
  `NLSS_ASSERT_NOW(a_pend_in_scan, pend_r, state_r == ST_SCAN, "compare pending outside a scan")
  `NLSS_ASSERT_NOW(a_hit_in_limit, (state_r != ST_IDLE) && hit_r, best_r < DW'(max_offset_r), "best distance not below the maximum offset")
  `NLSS_ASSERT_NOW(a_miss_index_zero, out_valid_r && !out_data_r.found, out_data_r.symbol_index == 8'd0, "miss result carries a nonzero index")
  `NLSS_ASSERT_NEXT(a_query_starts_scan, in_valid && !in_stall && (in_data.cmd == CMD_QUERY), state_r == ST_SCAN, "accepted query did not start a scan")

endmodule

[tb/nearest_lower_symbol_search_tb.sv]
`timescale 1ns / 100ps

module nearest_lower_symbol_search_tb;
  import nlss_pkg::*;

  localparam int DEPTH       = 256;
  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_USER_COUNT;
  logic [31:0] cfg_wdata = '0;

  nearest_lower_symbol_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Items waiting to be offered, and lookup answers waiting to come back.
  in_item_t    item_queue[$];
  out_item_t   answer_queue[$];
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned answers_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;

  // Shadow copy of both symbol tables and the three registers.
  logic [31:0] user_syms     [0:DEPTH-1];
  logic [31:0] internal_syms [0:DEPTH-1];
  logic [8:0]  user_count_r     = '0;
  logic [8:0]  internal_count_r = '0;
  logic [31:0] max_offset_r     = MAX_OFFSET_RESET;

  // Values the stimulus has written, so that queries can be aimed near symbols.
  logic [31:0] planned_syms [0:1][0:DEPTH-1];

  initial begin
    forever #1 clk = ~clk;
  end

  // Closest symbol at or below the address, strictly within the max offset.
  function automatic out_item_t nearest_below(logic sel, logic [31:0] addr);
    out_item_t   ans;
    logic [8:0]  cnt;
    logic [31:0] best;
    logic [31:0] sym;
    cnt = (sel == TBL_INTERNAL) ? internal_count_r : user_count_r;
    if (cnt > DEPTH) cnt = 9'(DEPTH);
    best = max_offset_r;
    ans = '0;
    ans.offset = addr;
    for (int i = 0; i < cnt; i++) begin
      sym = (sel == TBL_INTERNAL) ? internal_syms[i] : user_syms[i];
      if (sym <= addr && addr - sym < best) begin
        best = addr - sym;
        ans.found = 1'b1;
        ans.symbol_index = 8'(i);
        ans.offset = best;
      end
    end
    return ans;
  endfunction

  // Apply one accepted transfer to the shadow tables or queue its answer.
  function automatic void absorb_item(in_item_t it);
    if (it.cmd == CMD_WRITE) begin
      if (it.table_sel == TBL_INTERNAL) internal_syms[it.entry_index] = it.entry_value;
      else user_syms[it.entry_index] = it.entry_value;
    end else begin
      answer_queue.push_back(nearest_below(it.table_sel, it.address));
    end
  endfunction

  function automatic logic [31:0] region_base(int unsigned k);
    case (k)
      0: return 32'h0000_0000;
      1: return 32'h4000_0000;
      2: return 32'h8000_0000;
      default: return 32'hFFFF_C000;
    endcase
  endfunction

  // Symbol values cluster on a 64-byte grid so that ties are common.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h0000_0000;
      2: return 32'hFFFF_FFFF;
      default: return region_base($urandom_range(0, 3)) + ($urandom_range(0, 255) << 6);
    endcase
  endfunction

  // Half of the queries land on a written symbol plus zero, a distance around the limit, or a random distance.
  function automatic logic [31:0] pick_address(logic sel, int unsigned span, logic [31:0] mo);
    logic [31:0] delta;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return region_base($urandom_range(0, 3)) + $urandom_range(0, 20000);
      default: begin
        if (span == 0) return $urandom;
        case ($urandom_range(0, 3))
          0: delta = '0;
          1: delta = mo - 1;
          2: delta = mo;
          default: delta = $urandom_range(0, 20000);
        endcase
        return planned_syms[sel][$urandom_range(0, span - 1)] + delta;
      end
    endcase
  endfunction

  function automatic void push_write(logic sel, logic [7:0] idx, logic [31:0] val);
    in_item_t it;
    it.cmd = CMD_WRITE;
    it.table_sel = sel;
    it.entry_index = idx;
    it.entry_value = val;
    it.address = $urandom;
    planned_syms[sel][idx] = val;
    item_queue.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_query(logic sel, logic [31:0] addr);
    in_item_t it;
    it.cmd = CMD_QUERY;
    it.table_sel = sel;
    it.entry_index = 8'($urandom_range(0, 255));
    it.entry_value = $urandom;
    it.address = addr;
    item_queue.push_back(it);
    items_queued++;
  endfunction

  // Wait until every item has been taken and answered, then let the block settle.
  task automatic drain();
    while (items_taken != items_queued || answer_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Count registers get random upper bits, which the block must ignore.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] word;
    word = val;
    if (idx != CFG_MAX_OFFSET) word[31:9] = 23'($urandom);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_USER_COUNT:     user_count_r = word[8:0];
      CFG_INTERNAL_COUNT: internal_count_r = word[8:0];
      default:            max_offset_r = word;
    endcase
  endtask

  task automatic load_config(logic [8:0] uc, logic [8:0] ic, logic [31:0] mo);
    drain();
    write_reg(CFG_USER_COUNT, {23'd0, uc});
    write_reg(CFG_INTERNAL_COUNT, {23'd0, ic});
    write_reg(CFG_MAX_OFFSET, mo);
  endtask

  // One setting of the registers followed by a random mix of writes and queries.
  task automatic run_phase(logic [8:0] uc, logic [8:0] ic, logic [31:0] mo,
                           int unsigned idle, int unsigned n);
    logic        sel;
    int unsigned span;
    load_config(uc, ic, mo);
    in_idle_pct = idle;
    out_idle_pct = idle;
    repeat (n) begin
      sel = 1'($urandom_range(0, 1));
      span = (sel == TBL_INTERNAL) ? 32'(ic) : 32'(uc);
      if (span > DEPTH) span = DEPTH;
      if ($urandom_range(0, 99) < 45) begin
        if (span != 0 && $urandom_range(0, 9) < 7)
          push_write(sel, 8'($urandom_range(0, span - 1)), pick_value());
        else
          push_write(sel, 8'($urandom_range(0, DEPTH - 1)), pick_value());
      end else begin
        push_query(sel, pick_address(sel, span, mo));
      end
    end
  endtask

  // Input driver: offers queued items, with random gaps between transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        items_taken++;
        absorb_item(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_queue.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (item_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= item_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall. Every so often the receiver holds off
  // for a long stretch so that the block backs up and stalls its input.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answer_queue.size() == 0) begin
          $error("unexpected result: found %0d, symbol_index %0d, offset %h",
                 out_data.found, out_data.symbol_index, out_data.offset);
          mismatches++;
        end else begin
          want = answer_queue.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            mismatches++;
          end
          if (out_data.symbol_index !== want.symbol_index) begin
            $error("symbol_index: expected %0d, got %0d", want.symbol_index,
                   out_data.symbol_index);
            mismatches++;
          end
          if (out_data.offset !== want.offset) begin
            $error("offset: expected %h, got %h", want.offset, out_data.offset);
            mismatches++;
          end
        end
        if (answers_seen % 160 == 0 && out_idle_pct != 0) stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic sel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 20;
    out_idle_pct = 20;

    // Empty tables: nothing can be found.
    push_query(TBL_USER, 32'h0000_0000);
    push_query(TBL_INTERNAL, 32'hFFFF_FFFF);
    // A tie at 0x1000, both value extremes, and a small internal table.
    push_write(TBL_USER, 8'd0, 32'h0000_1000);
    push_write(TBL_USER, 8'd1, 32'h0000_1000);
    push_write(TBL_USER, 8'd2, 32'hFFFF_FFFF);
    push_write(TBL_USER, 8'd3, 32'h0000_0000);
    push_write(TBL_INTERNAL, 8'd0, 32'h0000_0000);
    push_write(TBL_INTERNAL, 8'd1, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_USER_COUNT, 32'd4);
    write_reg(CFG_INTERNAL_COUNT, 32'd2);
    // Max offset still at its reset value: exact hit on the tie, just below it, one below the
    // limit, exactly at the limit, and the top of the address space.
    push_query(TBL_USER, 32'h0000_1000);
    push_query(TBL_USER, 32'h0000_0FFF);
    push_query(TBL_USER, 32'h0000_1FFF);
    push_query(TBL_USER, 32'h0000_2000);
    push_query(TBL_USER, 32'hFFFF_FFFF);
    push_query(TBL_INTERNAL, 32'hFFFF_FFFF);
    push_query(TBL_INTERNAL, 32'h0000_0005);
    // A zero max offset lets nothing qualify.
    load_config(9'd4, 9'd1, 32'd0);
    push_query(TBL_USER, 32'h0000_1000);
    // The widest max offset still excludes a distance of all ones.
    load_config(9'd4, 9'd1, 32'hFFFF_FFFF);
    push_query(TBL_INTERNAL, 32'hFFFF_FFFF);
    push_query(TBL_INTERNAL, 32'hFFFF_FFFE);
    push_query(TBL_USER, 32'h0000_0000);
    load_config(9'd4, 9'd2, 32'd1);
    push_query(TBL_USER, 32'h0000_1000);
    push_query(TBL_USER, 32'h0000_1001);

    // Fill both tables completely, with queries on the first eight entries.
    load_config(9'd8, 9'd8, MAX_OFFSET_RESET);
    for (int i = 0; i < DEPTH; i++) begin
      push_write(TBL_USER, 8'(i), pick_value());
      push_write(TBL_INTERNAL, 8'(i), pick_value());
      if (i >= 8 && i % 4 == 0) begin
        sel = 1'($urandom_range(0, 1));
        push_query(sel, pick_address(sel, 8, MAX_OFFSET_RESET));
      end
    end

    // Random phases, including full and oversized counts; the last two run
    // without any idling.
    run_phase(9'd5,   9'd12,  32'd4096,      25, 95);
    run_phase(9'd256, 9'd3,   32'h0001_0000, 15, 95);
    run_phase(9'd1,   9'd300, 32'd100,       30, 95);
    run_phase(9'd0,   9'd511, 32'hFFFF_FFFF, 10, 95);
    run_phase(9'd16,  9'd0,   32'd1,         20, 95);
    run_phase(9'd20,  9'd7,   32'd0,         25, 95);
    run_phase(9'd9,   9'd256, $urandom,      0,  95);
    run_phase(9'd3,   9'd6,   32'd2000,      0,  95);

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
